>>> src/sliding_window_receiver_macros.svh
// Assertion macros used by the sliding window receiver top level.
`ifndef SLIDING_WINDOW_RECEIVER_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/swr_pkg.sv
// Types and constants of the sliding window receiver.
`timescale 1ns / 1ps

package swr_pkg;

    localparam int WIN_MAX = 64;
    localparam int WIN_W   = ($clog2(WIN_MAX + 1) > 7) ? $clog2(WIN_MAX + 1) : 7;
    localparam int SLOT_W  = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
    localparam int SEQ_W   = 31;

    localparam logic [6:0] WIN_RESET = 7'd8;

    localparam logic REQ_SEGMENT = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [31:0] SEQ_PROBE   = 32'hFFFF_FFFE;
    localparam logic [31:0] SEQ_FIN     = 32'hFFFF_FFF8;
    localparam logic [31:0] SEQ_FINAL   = 32'hFFFF_FFF7;
    localparam logic [31:0] ACK_CLOSING = 32'hFFFF_FFF6;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] seq_number;
        logic [31:0]        send_stamp;
    } t_item;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] ack_number;
        logic [6:0]         window_advert;
        logic [31:0]        echo_stamp;
        logic               accepted;
        logic [5:0]         buffer_slot;
        logic [30:0]        delivered_seq;
    } t_result;

endpackage

>>> src/sliding_window_receiver.sv
// Top level of the sliding window receiver.
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one item per handshake: a
// segment (i_req_type 0) with its sequence number and sender timestamp, or a
// consume request (i_req_type 1) that releases the oldest buffered slot.
// The output channel (o_out_valid / i_out_ready) returns exactly one result per
// item: an acknowledgement, a delivered segment or a nothing-to-deliver notice.
// The user must write the window size through i_cfg_we / i_cfg_wdata only while
// no item is in flight; the block itself does not enforce this. It takes effect for the next item.
// An item taken at a clock edge is held in the input register, updated against
// the receiver state and held again in the result register, which drives the
// output. Throughput is one item per cycle while the output is not stalled, set
// by the state update between the input register and the result register.
// When the consumer holds i_out_ready low, the result register keeps its item
// and the input register keeps the next one, so two items can wait; then
// o_in_ready drops until the output drains.
// A synchronous reset clears all sequence, slot and flag state, empties both
// registers and restores a window of eight slots.
`timescale 1ns / 1ps
`include "sliding_window_receiver_macros.svh"

module sliding_window_receiver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic signed [31:0] i_seq_number,
    input  logic [31:0]        i_send_stamp,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_result_kind,
    output logic signed [31:0] o_ack_number,
    output logic [6:0]         o_window_advert,
    output logic [31:0]        o_echo_stamp,
    output logic               o_accepted,
    output logic [5:0]         o_buffer_slot,
    output logic [30:0]        o_delivered_seq
);

    swr_pkg::t_item   w_in_item;
    swr_pkg::t_item   w_reg_item;
    swr_pkg::t_result w_eng_result;
    swr_pkg::t_result w_out_result;
    logic             w_reg_valid;
    logic             w_advance;
    logic             w_fire;

    assign w_in_item.req_type   = i_req_type;
    assign w_in_item.seq_number = i_seq_number;
    assign w_in_item.send_stamp = i_send_stamp;

    assign w_fire = w_reg_valid && w_advance;

    swr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_reg_valid),
        .o_item    (w_reg_item)
    );

    swr_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_item      (w_reg_item),
        .o_result    (w_eng_result)
    );

    swr_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_fire),
        .i_result  (w_eng_result),
        .o_advance (w_advance),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (w_out_result)
    );

    assign o_result_kind   = w_out_result.result_kind;
    assign o_ack_number    = w_out_result.ack_number;
    assign o_window_advert = w_out_result.window_advert;
    assign o_echo_stamp    = w_out_result.echo_stamp;
    assign o_accepted      = w_out_result.accepted;
    assign o_buffer_slot   = w_out_result.buffer_slot;
    assign o_delivered_seq = w_out_result.delivered_seq;

    `SWR_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_out_valid,
        "processed item did not produce a result")

    `SWR_ASSERT_NOW(a_accept_is_ack, i_clk, i_rst_n, o_out_valid && o_accepted,
        o_result_kind == swr_pkg::KIND_ACK, "accepted flag on a non-acknowledgement")

    `SWR_ASSERT_NOW(a_none_is_empty, i_clk, i_rst_n,
        o_out_valid && (o_result_kind == swr_pkg::KIND_NONE),
        (o_ack_number == 32'sd0) && (o_window_advert == 7'd0) && (o_buffer_slot == 6'd0),
        "nothing-to-deliver result carries data")

    `SWR_ASSERT_NOW(a_deliver_clean, i_clk, i_rst_n,
        o_out_valid && (o_result_kind == swr_pkg::KIND_DELIVER),
        (o_ack_number == 32'sd0) && (o_window_advert == 7'd0) && !o_accepted,
        "delivery result carries acknowledgement fields")

endmodule

>>> src/swr_in_reg.sv
// Input register stage that holds one accepted item for the engine.
`timescale 1ns / 1ps

module swr_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  swr_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output swr_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    swr_pkg::t_item r_item;
    logic           w_load;

    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> src/swr_engine.sv
// Receiver state and the single-pass update for one item.
`timescale 1ns / 1ps

module swr_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             i_fire,
    input  swr_pkg::t_item   i_item,
    output swr_pkg::t_result o_result
);

    logic [6:0]                   r_window_size;
    logic [swr_pkg::SEQ_W-1:0]    r_expected;
    logic [swr_pkg::SEQ_W-1:0]    n_expected;
    logic [swr_pkg::SEQ_W-1:0]    r_consumed;
    logic [swr_pkg::SEQ_W-1:0]    n_consumed;
    logic [swr_pkg::SLOT_W-1:0]   r_expect_slot;
    logic [swr_pkg::SLOT_W-1:0]   n_expect_slot;
    logic [swr_pkg::SLOT_W-1:0]   r_consume_slot;
    logic [swr_pkg::SLOT_W-1:0]   n_consume_slot;
    logic [swr_pkg::WIN_MAX-1:0]  r_slot_full;
    logic [swr_pkg::WIN_MAX-1:0]  n_slot_full;
    logic                         r_probe;
    logic                         n_probe;
    logic                         r_fin;
    logic                         n_fin;
    logic                         r_final;
    logic                         n_final;
    logic [31:0]                  r_last_stamp;
    logic [31:0]                  n_last_stamp;
    logic [6:0]                   r_last_window;
    logic [6:0]                   n_last_window;

    logic [swr_pkg::WIN_W-1:0]    w_win;
    logic [swr_pkg::WIN_W-1:0]    w_pos_c;
    logic [swr_pkg::WIN_W-1:0]    w_pos_e;
    logic [swr_pkg::WIN_W-1:0]    w_pos_c_inc;
    logic [swr_pkg::WIN_W-1:0]    w_pos_e_inc;
    logic [swr_pkg::SEQ_W-1:0]    w_out_cur;
    logic [swr_pkg::SEQ_W-1:0]    w_out_new;
    logic [swr_pkg::SEQ_W-1:0]    w_win_seq;
    logic [swr_pkg::SEQ_W-1:0]    w_free;
    logic [6:0]                   w_fresh;
    swr_pkg::t_result             w_res;

    always_comb begin
        w_win = swr_pkg::WIN_W'(r_window_size);
        if (r_window_size == 7'd0) begin
            w_win = swr_pkg::WIN_W'(1);
        end else if (swr_pkg::WIN_W'(r_window_size) > swr_pkg::WIN_W'(swr_pkg::WIN_MAX)) begin
            w_win = swr_pkg::WIN_W'(swr_pkg::WIN_MAX);
        end
        w_win_seq = swr_pkg::SEQ_W'(w_win);

        // Slot positions at or beyond the window restart at zero.
        w_pos_c = swr_pkg::WIN_W'(r_consume_slot);
        if (w_pos_c >= w_win) begin
            w_pos_c = '0;
        end
        w_pos_e = swr_pkg::WIN_W'(r_expect_slot);
        if (w_pos_e >= w_win) begin
            w_pos_e = '0;
        end
        w_pos_c_inc = w_pos_c + swr_pkg::WIN_W'(1);
        if (w_pos_c_inc >= w_win) begin
            w_pos_c_inc = '0;
        end
        w_pos_e_inc = w_pos_e + swr_pkg::WIN_W'(1);
        if (w_pos_e_inc >= w_win) begin
            w_pos_e_inc = '0;
        end

        w_out_cur = r_expected - r_consumed;

        n_expected     = r_expected;
        n_consumed     = r_consumed;
        n_expect_slot  = r_expect_slot;
        n_consume_slot = r_consume_slot;
        n_slot_full    = r_slot_full;
        n_probe        = r_probe;
        n_fin          = r_fin;
        n_final        = r_final;
        n_last_stamp   = r_last_stamp;
        n_last_window  = r_last_window;
        w_res          = '0;

        if (i_item.req_type == swr_pkg::REQ_CONSUME) begin
            if (w_out_cur != '0 && r_slot_full[w_pos_c[swr_pkg::SLOT_W-1:0]]) begin
                n_slot_full[w_pos_c[swr_pkg::SLOT_W-1:0]] = 1'b0;
                w_res.result_kind   = swr_pkg::KIND_DELIVER;
                w_res.buffer_slot   = 6'(w_pos_c);
                w_res.delivered_seq = r_consumed;
                n_consumed          = r_consumed + swr_pkg::SEQ_W'(1);
                n_consume_slot      = w_pos_c_inc[swr_pkg::SLOT_W-1:0];
            end else begin
                w_res.result_kind = swr_pkg::KIND_NONE;
            end
        end else begin
            w_res.result_kind = swr_pkg::KIND_ACK;
            if (i_item.seq_number == swr_pkg::SEQ_PROBE) begin
                n_probe = 1'b1;
            end else if (i_item.seq_number == swr_pkg::SEQ_FIN) begin
                n_fin = 1'b1;
            end else if (i_item.seq_number == swr_pkg::SEQ_FINAL) begin
                n_final = 1'b1;
            end else if (i_item.seq_number == {1'b0, r_expected}) begin
                if (!r_slot_full[w_pos_e[swr_pkg::SLOT_W-1:0]]) begin
                    n_slot_full[w_pos_e[swr_pkg::SLOT_W-1:0]] = 1'b1;
                    w_res.accepted    = 1'b1;
                    w_res.buffer_slot = 6'(w_pos_e);
                    n_expected        = r_expected + swr_pkg::SEQ_W'(1);
                    n_expect_slot     = w_pos_e_inc[swr_pkg::SLOT_W-1:0];
                    n_last_stamp      = i_item.send_stamp;
                end
            end
        end

        w_out_new = n_expected - r_consumed;
        w_free    = (w_out_new >= w_win_seq) ? '0 : w_win_seq - w_out_new;
        w_fresh   = w_free[6:0];

        if (i_item.req_type == swr_pkg::REQ_SEGMENT) begin
            if (n_probe) begin
                w_res.ack_number    = swr_pkg::SEQ_PROBE;
                w_res.window_advert = w_fresh;
                n_last_window       = w_fresh;
                if (w_fresh != 7'd0) begin
                    n_probe = 1'b0;
                end
            end else if (n_fin && !n_final) begin
                w_res.ack_number    = swr_pkg::SEQ_FINAL;
                w_res.window_advert = r_last_window;
            end else if (n_final) begin
                w_res.ack_number    = swr_pkg::ACK_CLOSING;
                w_res.window_advert = r_last_window;
            end else begin
                w_res.ack_number    = {1'b0, n_expected};
                w_res.window_advert = w_fresh;
                n_last_window       = w_fresh;
            end
            w_res.echo_stamp = n_last_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= swr_pkg::WIN_RESET;
            r_expected     <= '0;
            r_consumed     <= '0;
            r_expect_slot  <= '0;
            r_consume_slot <= '0;
            r_slot_full    <= '0;
            r_probe        <= 1'b0;
            r_fin          <= 1'b0;
            r_final        <= 1'b0;
            r_last_stamp   <= '0;
            r_last_window  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_expected     <= n_expected;
                r_consumed     <= n_consumed;
                r_expect_slot  <= n_expect_slot;
                r_consume_slot <= n_consume_slot;
                r_slot_full    <= n_slot_full;
                r_probe        <= n_probe;
                r_fin          <= n_fin;
                r_final        <= n_final;
                r_last_stamp   <= n_last_stamp;
                r_last_window  <= n_last_window;
            end
        end
    end

    assign o_result = w_res;

endmodule

>>> src/swr_out_reg.sv
// Result register stage that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module swr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  swr_pkg::t_result i_result,
    output logic             o_advance,
    output logic             o_valid,
    input  logic             i_ready,
    output swr_pkg::t_result o_result
);

    logic             r_valid;
    logic             n_valid;
    swr_pkg::t_result r_result;

    assign o_advance = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> dv/sliding_window_receiver_checker.sv
// Scoreboard that predicts and checks every result of the sliding window receiver.
`timescale 1ns / 1ps

module sliding_window_receiver_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_req_type,
    input  logic signed [31:0] i_seq_number,
    input  logic [31:0]        i_send_stamp,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_result_kind,
    input  logic signed [31:0] i_ack_number,
    input  logic [6:0]         i_window_advert,
    input  logic [31:0]        i_echo_stamp,
    input  logic               i_accepted,
    input  logic [5:0]         i_buffer_slot,
    input  logic [30:0]        i_delivered_seq,
    output int                 o_fail_count,
    output int                 o_pending
);
    import swr_pkg::*;

    logic [6:0]  window_reg;
    logic [30:0] next_expected;
    logic [30:0] next_consumed;
    int          fill_pos;
    int          drain_pos;
    bit          occupied [WIN_MAX];
    logic        probe_open;
    logic        fin_open;
    logic        closing;
    logic [31:0] echo_hold;
    logic [6:0]  advert_hold;
    t_result     owed_responses [$];

    task automatic reset_receiver();
        window_reg = WIN_RESET;
        next_expected = '0;
        next_consumed = '0;
        fill_pos = 0;
        drain_pos = 0;
        for (int i = 0; i < WIN_MAX; i++) begin
            occupied[i] = 1'b0;
        end
        probe_open = 1'b0;
        fin_open = 1'b0;
        closing = 1'b0;
        echo_hold = '0;
        advert_hold = '0;
    endtask

    function automatic int usable_slots();
        int w;
        w = int'(window_reg);
        if (w == 0) begin
            w = 1;
        end
        if (w > WIN_MAX) begin
            w = WIN_MAX;
        end
        return w;
    endfunction

    function automatic int wrap_pos(input int pos, input int w);
        return (pos >= w) ? 0 : pos;
    endfunction

    function automatic logic [6:0] refresh_advert(input int w);
        logic [30:0] outstanding;
        int          free_slots;
        outstanding = next_expected - next_consumed;
        free_slots = (outstanding >= w) ? 0 : w - outstanding;
        advert_hold = free_slots[6:0];
        return advert_hold;
    endfunction

    function automatic t_result advance_receiver(input t_item it);
        t_result     r;
        logic [31:0] seq;
        logic [30:0] outstanding;
        int          w;
        int          pos;
        r = '0;
        w = usable_slots();
        if (it.req_type == REQ_CONSUME) begin
            pos = wrap_pos(drain_pos, w);
            outstanding = next_expected - next_consumed;
            if (outstanding != '0 && occupied[pos]) begin
                occupied[pos] = 1'b0;
                r.result_kind = KIND_DELIVER;
                r.buffer_slot = pos[5:0];
                r.delivered_seq = next_consumed;
                next_consumed = next_consumed + 31'd1;
                drain_pos = wrap_pos(pos + 1, w);
            end else begin
                r.result_kind = KIND_NONE;
            end
        end else begin
            seq = it.seq_number;
            if (seq == SEQ_PROBE) begin
                probe_open = 1'b1;
            end else if (seq == SEQ_FIN) begin
                fin_open = 1'b1;
            end else if (seq == SEQ_FINAL) begin
                closing = 1'b1;
            end else if (seq == {1'b0, next_expected}) begin
                pos = wrap_pos(fill_pos, w);
                if (!occupied[pos]) begin
                    occupied[pos] = 1'b1;
                    r.accepted = 1'b1;
                    r.buffer_slot = pos[5:0];
                    next_expected = next_expected + 31'd1;
                    fill_pos = wrap_pos(pos + 1, w);
                    echo_hold = it.send_stamp;
                end
            end
            r.result_kind = KIND_ACK;
            if (probe_open) begin
                r.ack_number = SEQ_PROBE;
                r.window_advert = refresh_advert(w);
                if (r.window_advert != '0) begin
                    probe_open = 1'b0;
                end
            end else if (fin_open && !closing) begin
                // While waiting for the final ack the answer reuses the final-ack code.
                r.ack_number = SEQ_FINAL;
                r.window_advert = advert_hold;
            end else if (closing) begin
                r.ack_number = ACK_CLOSING;
                r.window_advert = advert_hold;
            end else begin
                r.ack_number = {1'b0, next_expected};
                r.window_advert = refresh_advert(w);
            end
            r.echo_stamp = echo_hold;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            if (o_fail_count < 10) begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_item   item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            reset_receiver();
            owed_responses.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                window_reg = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                item.req_type = i_req_type;
                item.seq_number = i_seq_number;
                item.send_stamp = i_send_stamp;
                owed_responses.push_back(advance_receiver(item));
            end
            if (i_out_valid && i_out_ready) begin
                got.result_kind = i_result_kind;
                got.ack_number = i_ack_number;
                got.window_advert = i_window_advert;
                got.echo_stamp = i_echo_stamp;
                got.accepted = i_accepted;
                got.buffer_slot = i_buffer_slot;
                got.delivered_seq = i_delivered_seq;
                if (owed_responses.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: result with no item outstanding: %h", $time, got);
                    end
                    o_fail_count++;
                end else begin
                    want = owed_responses.pop_front();
                    compare_field("result_kind", want.result_kind, got.result_kind);
                    compare_field("ack_number", want.ack_number, got.ack_number);
                    compare_field("window_advert", want.window_advert, got.window_advert);
                    compare_field("echo_stamp", want.echo_stamp, got.echo_stamp);
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("buffer_slot", want.buffer_slot, got.buffer_slot);
                    compare_field("delivered_seq", want.delivered_seq, got.delivered_seq);
                end
            end
        end
        o_pending = owed_responses.size();
    end

endmodule

>>> dv/sliding_window_receiver_test.sv
// Top of the sliding window receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sliding_window_receiver_test;
    import swr_pkg::*;

    localparam int LONG_HOLD = 60;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [6:0]         cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = REQ_SEGMENT;
    logic signed [31:0] seq_number = '0;
    logic [31:0]        send_stamp = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         result_kind;
    logic signed [31:0] ack_number;
    logic [6:0]         window_advert;
    logic [31:0]        echo_stamp;
    logic               accepted;
    logic [5:0]         buffer_slot;
    logic [30:0]        delivered_seq;
    int                 fail_count;
    int                 pending;

    logic [30:0] tx_seq = '0;
    int          tx_out = 0;
    int          cfg_window = 8;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          segments_sent = 0;
    int          consumes_sent = 0;
    int          window_writes = 0;

    int phase_window [8] = '{1, 64, 3, 127, 0, 16, 5, 64};
    int phase_idle [8]   = '{0, 77, 0, 13, 0, 77, 0, 13};
    int phase_stall [8]  = '{0, 0, 77, 13, 0, 0, 77, 13};

    sliding_window_receiver DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_seq_number    (seq_number),
        .i_send_stamp    (send_stamp),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_result_kind   (result_kind),
        .o_ack_number    (ack_number),
        .o_window_advert (window_advert),
        .o_echo_stamp    (echo_stamp),
        .o_accepted      (accepted),
        .o_buffer_slot   (buffer_slot),
        .o_delivered_seq (delivered_seq)
    );

    sliding_window_receiver_checker scoreboard (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_seq_number    (seq_number),
        .i_send_stamp    (send_stamp),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_result_kind   (result_kind),
        .i_ack_number    (ack_number),
        .i_window_advert (window_advert),
        .i_echo_stamp    (echo_stamp),
        .i_accepted      (accepted),
        .i_buffer_slot   (buffer_slot),
        .i_delivered_seq (delivered_seq),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("sliding_window_receiver regression: fail");
        $finish;
    end

    initial begin : receiver
        int holds_served;
        holds_served = 0;
        forever begin
            @(posedge clk);
            if (hold_request != holds_served) begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    function automatic int slots_for(input int setting);
        if (setting == 0) begin
            return 1;
        end
        return (setting > WIN_MAX) ? WIN_MAX : setting;
    endfunction

    // The sender tracks the next in-order sequence and the buffered count so that
    // most segments it offers are the ones the receiver is waiting for.
    task automatic push_item(input logic kind, input logic [31:0] seq,
                             input logic [31:0] stamp);
        if ($urandom_range(99, 0) < idle_pct) begin
            in_valid <= 1'b0;
            do begin
                @(posedge clk);
            end while ($urandom_range(99, 0) < idle_pct);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        seq_number <= seq;
        send_stamp <= stamp;
        do begin
            @(posedge clk);
        end while (!in_ready);
        if (kind == REQ_CONSUME) begin
            consumes_sent++;
            if (tx_out > 0) begin
                tx_out--;
            end
        end else begin
            segments_sent++;
            if (seq == {1'b0, tx_seq} && tx_out < slots_for(cfg_window)) begin
                tx_seq = tx_seq + 31'd1;
                tx_out++;
            end
        end
    endtask

    task automatic push_segment(input logic [31:0] seq);
        push_item(REQ_SEGMENT, seq, $urandom);
    endtask

    task automatic push_consume();
        push_item(REQ_CONSUME, $urandom, $urandom);
    endtask

    task automatic release_buffered();
        int n;
        n = tx_out + 1;
        repeat (n) push_consume();
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value[6:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_window = value;
        window_writes++;
        @(posedge clk);
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] noise;
        logic [30:0] behind;
        logic [30:0] ahead;
        pick = $urandom_range(99, 0);
        noise = $urandom;
        if (noise == SEQ_FIN || noise == SEQ_FINAL) begin
            noise = ~noise;
        end
        behind = tx_seq - 31'd1;
        ahead = tx_seq + 31'd1 + 31'($urandom_range(7, 0));
        if (pick < 40) begin
            push_segment({1'b0, tx_seq});
        end else if (pick < 75) begin
            push_consume();
        end else if (pick < 82) begin
            push_segment({1'b0, behind});
        end else if (pick < 88) begin
            push_segment({1'b0, ahead});
        end else if (pick < 92) begin
            push_segment(SEQ_PROBE);
        end else begin
            push_segment(noise);
        end
    endtask

    initial begin : stimulus
        int phase;
        int waited;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_consume();
        push_item(REQ_SEGMENT, 32'd0, 32'h0000_0000);
        push_item(REQ_SEGMENT, 32'd0, 32'hFFFF_FFFF);
        push_segment(32'd5);
        push_segment(32'h7FFF_FFFF);
        push_segment(32'h8000_0000);
        push_segment(32'hFFFF_FFFF);
        push_segment(SEQ_PROBE);
        push_item(REQ_SEGMENT, 32'd1, 32'hFFFF_FFFF);
        push_item(REQ_SEGMENT, 32'd2, 32'hAAAA_AAAA);
        push_item(REQ_SEGMENT, 32'd3, 32'h5555_5555);
        settle();
        // Shrinking below the buffered count leaves the window overfull.
        write_window(2);
        push_segment(32'd4);
        push_segment(SEQ_PROBE);
        push_segment(32'd4);
        settle();
        write_window(8);
        push_segment(32'd4);
        release_buffered();

        for (phase = 0; phase < 8; phase++) begin
            settle();
            idle_pct = phase_idle[phase];
            stall_pct <= phase_stall[phase];
            write_window(phase_window[phase]);
            if (phase == 4) begin
                hold_request <= hold_request + 1;
            end
            repeat (75) random_item();
            release_buffered();
        end

        settle();
        idle_pct = 13;
        stall_pct <= 13;
        write_window(8);
        push_segment(SEQ_FIN);
        push_segment({1'b0, tx_seq});
        push_segment(SEQ_PROBE);
        push_segment({1'b0, tx_seq});
        push_segment(SEQ_FIN);
        push_segment(SEQ_FINAL);
        push_segment({1'b0, tx_seq});
        push_segment({1'b0, tx_seq + 31'd5});
        release_buffered();
        settle();
        write_window(1);
        push_segment({1'b0, tx_seq});
        push_consume();
        settle();
        write_window(4);
        repeat (3) push_segment({1'b0, tx_seq});
        settle();
        // With the window cut to two, the third consume finds the oldest slot empty.
        write_window(2);
        repeat (3) push_consume();

        in_valid <= 1'b0;
        waited = 0;
        @(negedge clk);
        while (pending != 0 && waited < 5000) begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        $display("Covered %0d segments and %0d consume requests over %0d window writes,",
                 segments_sent, consumes_sent, window_writes);
        $display("with idle and stall mixes, a long output hold-off and the closing codes.");
        if (fail_count == 0 && pending == 0) begin
            $display("sliding_window_receiver regression: pass");
        end else begin
            $display("sliding_window_receiver regression: fail");
        end
        $finish;
    end

endmodule
